>>> rtl/tiling_value_noise_fbm_macros.svh
// Assertion macros for the tiling value noise fBm checker.
// Expects clk_i and rst_ni in the scope of use.
`ifndef TILING_VALUE_NOISE_FBM_MACROS_SVH
`define TILING_VALUE_NOISE_FBM_MACROS_SVH

// same-cycle implication
`define TVN_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TVN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tvn_pkg.sv
// Shared types, constants and helpers of the tiling value noise fBm block.
// No dependencies.
`default_nettype none

package tvn_pkg;

  localparam int unsigned MaxOctavesDef = 8;
  localparam int unsigned FracBitsDef   = 16;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned NoiseW  = 16;
  localparam int unsigned FreqW   = 48;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned AmpW    = 17;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned OctCfgW = 4;
  localparam int unsigned HashW   = 24;

  localparam logic [31:0] HashMulX   = 32'd374761393;
  localparam logic [31:0] HashMulY   = 32'd668265263;
  localparam logic [31:0] HashMulMix = 32'd1274126177;
  localparam logic [17:0] FadeK      = 18'd196608;

  localparam logic [FreqW-1:0]   FreqOne     = 48'd4096;
  localparam logic [FreqW-1:0]   FreqCap     = 48'h8000_0000_0000;
  localparam logic [AmpW-1:0]    AmpOne      = 17'h1_0000;
  localparam logic [PeriodW-1:0] PeriodReset = 32'd256;

  localparam logic [CfgW-1:0]    TilePeriodReset  = 16'd256;
  localparam logic [OctCfgW-1:0] OctaveCountReset = 4'd4;
  localparam logic [CfgW-1:0]    LacunarityReset  = 16'd8192;
  localparam logic [CfgW-1:0]    OctaveGainReset  = 16'd32768;

  localparam logic [1:0] RegTilePeriod  = 2'd0;
  localparam logic [1:0] RegOctaveCount = 2'd1;
  localparam logic [1:0] RegLacunarity  = 2'd2;
  localparam logic [1:0] RegOctaveGain  = 2'd3;

  typedef struct packed {
    logic [FreqW-1:0]   freq;
    logic [PeriodW-1:0] period;
    logic [AmpW-1:0]    amp;
  } oct_par_t;

  localparam oct_par_t ParReset = '{freq: FreqOne, period: PeriodReset, amp: AmpOne};

  typedef enum logic [4:0] {
    StIdle, StMxl, StMxh, StMyl, StMyh, StSy, StFin, StModI, StMod, StWrap,
    StHx0, StHx1, StHy0, StHy1, StMx00, StMx10, StMx01, StMx11,
    StSqx, StFdx, StSqy, StFdy, StLra, StLrb, StLrc, StAcc, StSum,
    StDivI, StDiv, StDone
  } state_e;

  // coord * freq product (Q.12) to saturated signed 32 bits, floor; {sat, value}
  function automatic logic [32:0] scale_fin(input logic [79:0] p, input logic neg);
    logic [67:0] q;
    logic [32:0] r;
    q = 68'(p[79:12]) + 68'(|p[11:0]);
    if (!neg) begin
      r = (|p[79:43]) ? {1'b1, 32'h7FFF_FFFF} : {2'b00, p[42:12]};
    end else if (q > 68'h8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, 32'(~q[31:0] + 32'd1)};
    end
    return r;
  endfunction

  function automatic logic [31:0] hash_premix(input logic [31:0] s);
    return s ^ (s >> 13);
  endfunction

  function automatic logic [HashW-1:0] hash_fin(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    return t[HashW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/tvn_cell.sv
// One octave cell: holds freq, period and amplitude of its octave and
// hands the next octave's values to its neighbor. Uses tvn_pkg.
`default_nettype none

module tvn_cell import tvn_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire oct_par_t      par_i,
  input  wire logic [CfgW-1:0] lac_i,
  input  wire logic [CfgW-1:0] gain_i,
  output oct_par_t           par_o,
  output oct_par_t           next_o
);

  oct_par_t    par_q;
  logic [63:0] fprod;
  logic [47:0] pprod;
  logic [32:0] aprod;
  logic [51:0] fnew;
  logic [35:0] pnew;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q <= ParReset;
    end else begin
      par_q <= par_i;
    end
  end

  always_comb begin
    fprod = 64'(par_q.freq) * 64'(lac_i);
    pprod = 48'(par_q.period) * 48'(lac_i);
    aprod = 33'(par_q.amp) * 33'(gain_i);
    fnew  = fprod[63:12];
    pnew  = pprod[47:12];
    next_o.freq   = (fnew > 52'(FreqCap)) ? FreqCap : fnew[FreqW-1:0];
    if (|pnew[35:32]) begin
      next_o.period = 32'hFFFF_FFFF;
    end else if (pnew == 36'd0) begin
      next_o.period = 32'd1;
    end else begin
      next_o.period = pnew[31:0];
    end
    next_o.amp = aprod[32:16];
  end

  assign par_o = par_q;

endmodule

`default_nettype wire

>>> rtl/tvn_engine.sv
// Octave sequencer: scaling, corner hash, fade, bilinear blend and weighted sum on one
// shared multiplier, with bit-serial lattice wrap and a final normalizing division. Uses tvn_pkg.
`default_nettype none

module tvn_engine import tvn_pkg::*; #(
  parameter int unsigned MAX_OCTAVES = MaxOctavesDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  localparam int unsigned OctW = $clog2(MAX_OCTAVES + 1),
  localparam int unsigned IdxW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CoordW-1:0] x_i,
  input  wire logic [CoordW-1:0] y_i,
  input  wire logic [OctW-1:0]   oct_n_i,
  input  wire oct_par_t          par_i,
  output logic [IdxW-1:0]        oct_idx_o,
  output logic                   ready_o,
  output logic                   res_valid_o,
  input  wire logic              res_take_i,
  output logic [NoiseW-1:0]      noise_o,
  output logic                   sat_o
);

  localparam int unsigned IW     = 32 - FRAC_BITS;
  localparam int unsigned FracSh = 32 - FRAC_BITS;
  localparam int unsigned SumW   = 41 + OctW;
  localparam int unsigned NormW  = AmpW + OctW;
  localparam int unsigned DivW   = NormW + 8;
  localparam int unsigned CntW   = $clog2(((IW > NoiseW) ? IW : NoiseW) + 1);

  state_e st_q, st_d;

  logic [31:0]        x_q, y_q, sx_q, sy_q, magx, magy;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic [55:0]        plo_q;
  logic [79:0]        pacc_q, pacc_new;
  logic [32:0]        scl;
  logic [IW-1:0]      dvx_q, dvy_q, rmx_q, rmy_q, nrx, nry, xi, yi;
  logic [IW:0]        ttx, tty;
  logic               gex, gey, negx_q, negy_q;
  logic [CntW-1:0]    cnt_q;
  logic [31:0]        x0_q, x1_q, y0_q, y1_q, xa0_q, xa1_q, yb0_q, yb1_q;
  logic [HashW-1:0]   h00_q, h10_q, h01_q, h11_q;
  logic [16:0]        u_q, v_q;
  logic signed [24:0] la_q, lb_now, lval, dif;
  logic [31:0]        fxs, fys;
  logic [15:0]        tx, ty;
  logic [OctW-1:0]    oct_q, n_q;
  logic [SumW-1:0]    sum_q;
  logic [NormW-1:0]   norm_q;
  logic [DivW-1:0]    rem_q;
  logic [DivW:0]      dtt, dden;
  logic               dge;
  logic [NoiseW-1:0]  quo_q;
  logic               sat_q;

  assign magx   = x_q[31] ? 32'(~x_q + 32'd1) : x_q;
  assign magy   = y_q[31] ? 32'(~y_q + 32'd1) : y_q;
  assign fxs    = sx_q << FracSh;
  assign fys    = sy_q << FracSh;
  assign tx     = fxs[31:16];
  assign ty     = fys[31:16];
  assign xi     = sx_q[31:FRAC_BITS];
  assign yi     = sy_q[31:FRAC_BITS];
  assign lb_now = $signed({1'b0, h01_q}) + $signed(prod_q[40:16]);
  assign lval   = la_q + $signed(prod_q[40:16]);
  assign pacc_new = 80'(plo_q) + (80'(prod_q[55:0]) << 24);
  assign scl    = scale_fin(pacc_q, (st_q == StMyh) ? x_q[31] : y_q[31]);

  // remainder lanes, one bit a cycle
  assign ttx = {rmx_q, dvx_q[IW-1]};
  assign tty = {rmy_q, dvy_q[IW-1]};
  assign gex = 33'(ttx) >= {1'b0, par_i.period};
  assign gey = 33'(tty) >= {1'b0, par_i.period};
  assign nrx = gex ? IW'(33'(ttx) - {1'b0, par_i.period}) : IW'(ttx);
  assign nry = gey ? IW'(33'(tty) - {1'b0, par_i.period}) : IW'(tty);

  // normalizing divider, one quotient bit a cycle
  assign dtt  = {rem_q, sum_q[NoiseW-1]};
  assign dden = {1'b0, norm_q, 8'd0};
  assign dge  = dtt >= dden;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (start_i) st_d = (oct_n_i == '0) ? StDone : StMxl;
      StMxl:   st_d = StMxh;
      StMxh:   st_d = StMyl;
      StMyl:   st_d = StMyh;
      StMyh:   st_d = StSy;
      StSy:    st_d = StFin;
      StFin:   st_d = StModI;
      StModI:  st_d = StMod;
      StMod:   if (cnt_q == CntW'(1)) st_d = StWrap;
      StWrap:  st_d = StHx0;
      StHx0:   st_d = StHx1;
      StHx1:   st_d = StHy0;
      StHy0:   st_d = StHy1;
      StHy1:   st_d = StMx00;
      StMx00:  st_d = StMx10;
      StMx10:  st_d = StMx01;
      StMx01:  st_d = StMx11;
      StMx11:  st_d = StSqx;
      StSqx:   st_d = StFdx;
      StFdx:   st_d = StSqy;
      StSqy:   st_d = StFdy;
      StFdy:   st_d = StLra;
      StLra:   st_d = StLrb;
      StLrb:   st_d = StLrc;
      StLrc:   st_d = StAcc;
      StAcc:   st_d = StSum;
      StSum:   st_d = (OctW'(oct_q + 1'b1) == n_q) ? StDivI : StMxl;
      StDivI:  st_d = StDiv;
      StDiv:   if (cnt_q == CntW'(1)) st_d = StDone;
      StDone:  if (res_take_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    dif   = '0;
    case (st_q)
      StMxl: begin mul_a = {1'b0, magx}; mul_b = 33'(par_i.freq[23:0]); end
      StMxh: begin mul_a = {1'b0, magx}; mul_b = 33'(par_i.freq[47:24]); end
      StMyl: begin mul_a = {1'b0, magy}; mul_b = 33'(par_i.freq[23:0]); end
      StMyh: begin mul_a = {1'b0, magy}; mul_b = 33'(par_i.freq[47:24]); end
      StHx0: begin mul_a = {1'b0, x0_q}; mul_b = {1'b0, HashMulX}; end
      StHx1: begin mul_a = {1'b0, x1_q}; mul_b = {1'b0, HashMulX}; end
      StHy0: begin mul_a = {1'b0, y0_q}; mul_b = {1'b0, HashMulY}; end
      StHy1: begin mul_a = {1'b0, y1_q}; mul_b = {1'b0, HashMulY}; end
      StMx00: begin
        mul_a = {1'b0, hash_premix(xa0_q + yb0_q)}; mul_b = {1'b0, HashMulMix};
      end
      StMx10: begin
        mul_a = {1'b0, hash_premix(xa1_q + yb0_q)}; mul_b = {1'b0, HashMulMix};
      end
      StMx01: begin
        mul_a = {1'b0, hash_premix(xa0_q + yb1_q)}; mul_b = {1'b0, HashMulMix};
      end
      StMx11: begin
        mul_a = {1'b0, hash_premix(xa1_q + yb1_q)}; mul_b = {1'b0, HashMulMix};
      end
      StSqx: begin mul_a = 33'(tx); mul_b = 33'(tx); end
      StFdx: begin
        mul_a = {1'b0, prod_q[31:0]}; mul_b = 33'(FadeK - {1'b0, tx, 1'b0});
      end
      StSqy: begin mul_a = 33'(ty); mul_b = 33'(ty); end
      StFdy: begin
        mul_a = {1'b0, prod_q[31:0]}; mul_b = 33'(FadeK - {1'b0, ty, 1'b0});
      end
      StLra: begin
        dif = $signed({1'b0, h10_q}) - $signed({1'b0, h00_q});
        mul_a = 33'(dif); mul_b = 33'(u_q);
      end
      StLrb: begin
        dif = $signed({1'b0, h11_q}) - $signed({1'b0, h01_q});
        mul_a = 33'(dif); mul_b = 33'(u_q);
      end
      StLrc: begin
        dif = lb_now - la_q;
        mul_a = 33'(dif); mul_b = 33'(v_q);
      end
      StAcc: begin mul_a = {8'd0, lval}; mul_b = 33'(par_i.amp); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      cnt_q <= '0;
      oct_q <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        StIdle:  if (start_i) oct_q <= '0;
        StModI:  cnt_q <= CntW'(IW);
        StMod:   cnt_q <= cnt_q - 1'b1;
        StSum:   oct_q <= OctW'(oct_q + 1'b1);
        StDivI:  cnt_q <= CntW'(NoiseW);
        StDiv:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (st_q)
      StIdle: if (start_i) begin
        x_q    <= x_i;
        y_q    <= y_i;
        n_q    <= oct_n_i;
        sum_q  <= '0;
        norm_q <= '0;
        sat_q  <= 1'b0;
        quo_q  <= '0;
      end
      StMxh:  plo_q  <= prod_q[55:0];
      StMyl:  pacc_q <= pacc_new;
      StMyh: begin
        plo_q <= prod_q[55:0];
        sx_q  <= scl[31:0];
        sat_q <= sat_q | scl[32];
      end
      StSy:   pacc_q <= pacc_new;
      StFin: begin
        sy_q  <= scl[31:0];
        sat_q <= sat_q | scl[32];
      end
      StModI: begin
        negx_q <= sx_q[31];
        negy_q <= sy_q[31];
        dvx_q  <= sx_q[31] ? IW'(~xi + 1'b1) : xi;
        dvy_q  <= sy_q[31] ? IW'(~yi + 1'b1) : yi;
        rmx_q  <= '0;
        rmy_q  <= '0;
      end
      StMod: begin
        rmx_q <= nrx;
        rmy_q <= nry;
        dvx_q <= dvx_q << 1;
        dvy_q <= dvy_q << 1;
      end
      StWrap: begin
        x0_q <= (negx_q && rmx_q != '0) ? par_i.period - 32'(rmx_q) : 32'(rmx_q);
        y0_q <= (negy_q && rmy_q != '0) ? par_i.period - 32'(rmy_q) : 32'(rmy_q);
      end
      StHx0: begin
        x1_q <= (33'(x0_q) + 33'd1 == {1'b0, par_i.period}) ? 32'd0 : x0_q + 32'd1;
        y1_q <= (33'(y0_q) + 33'd1 == {1'b0, par_i.period}) ? 32'd0 : y0_q + 32'd1;
      end
      StHx1:  xa0_q <= prod_q[31:0];
      StHy0:  xa1_q <= prod_q[31:0];
      StHy1:  yb0_q <= prod_q[31:0];
      StMx00: yb1_q <= prod_q[31:0];
      StMx10: h00_q <= hash_fin(prod_q[31:0]);
      StMx01: h10_q <= hash_fin(prod_q[31:0]);
      StMx11: h01_q <= hash_fin(prod_q[31:0]);
      StSqx:  h11_q <= hash_fin(prod_q[31:0]);
      StSqy:  u_q   <= prod_q[48:32];
      StLra:  v_q   <= prod_q[48:32];
      StLrb:  la_q  <= $signed({1'b0, h00_q}) + $signed(prod_q[40:16]);
      StSum: begin
        sum_q  <= sum_q + SumW'(prod_q[40:0]);
        norm_q <= norm_q + NormW'(par_i.amp);
      end
      StDivI: rem_q <= sum_q[SumW-1:NoiseW];
      StDiv: begin
        rem_q <= dge ? DivW'(dtt - dden) : DivW'(dtt);
        quo_q <= {quo_q[NoiseW-2:0], dge};
        sum_q <= {sum_q[SumW-1:NoiseW], sum_q[NoiseW-2:0], 1'b0};
      end
      default: sat_q <= sat_q;
    endcase
  end

  assign oct_idx_o   = oct_q[IdxW-1:0];
  assign ready_o     = (st_q == StIdle);
  assign res_valid_o = (st_q == StDone);
  assign noise_o     = quo_q;
  assign sat_o       = sat_q;

endmodule

`default_nettype wire

>>> rtl/tiling_value_noise_fbm.sv
// Top level of the tiling value noise fBm block: register port, octave cell chain,
// sequencer and output register. Uses tvn_pkg, tvn_cell, tvn_engine.
//
//   port group  dir  contents
//   s_axis_*    in   request: tdata = x_coord[31:0], y_coord[63:32]
//   m_axis_*    out  result: tdata = noise_value[15:0], tuser = coord_saturated
//   APB         in   tile_period 0x0, octave_count 0x4, lacunarity 0x8, octave_gain 0xC
//
// One request at a time. With n octaves (clamped to MAX_OCTAVES) each octave runs
// through the single shared multiplier and the bit-serial lattice wrap, and the
// bit-serial normalizing divider follows the last octave; n=0 goes straight to
// the output register.
// s_axis_tready returns once the result enters the output register, even while
// m_axis is stalled. The cell chain settles one octave per cycle after a write.
`default_nettype none

module tiling_value_noise_fbm import tvn_pkg::*; #(
  parameter int unsigned MAX_OCTAVES = MaxOctavesDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // x_coord, y_coord
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // noise_value
  output logic [0:0]       m_axis_tuser,   // coord_saturated
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned OctW = $clog2(MAX_OCTAVES + 1);
  localparam int unsigned IdxW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

  logic [CfgW-1:0]    tile_q, lac_q, gain_q;
  logic [OctCfgW-1:0] octs_q;
  logic               wr_en;

  oct_par_t chain_in [MAX_OCTAVES];
  oct_par_t cell_par [MAX_OCTAVES];
  oct_par_t cell_nxt [MAX_OCTAVES];

  logic [OctW-1:0]   oct_n;
  logic [IdxW-1:0]   oct_idx;
  logic              eng_ready, res_valid, res_take, res_sat;
  logic [NoiseW-1:0] res_noise;
  logic              m_valid_q, m_sat_q;
  logic [NoiseW-1:0] m_noise_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_q <= TilePeriodReset;
      octs_q <= OctaveCountReset;
      lac_q  <= LacunarityReset;
      gain_q <= OctaveGainReset;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegTilePeriod:  tile_q <= pwdata[CfgW-1:0];
        RegOctaveCount: octs_q <= pwdata[OctCfgW-1:0];
        RegLacunarity:  lac_q  <= pwdata[CfgW-1:0];
        RegOctaveGain:  gain_q <= pwdata[CfgW-1:0];
        default:        tile_q <= tile_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegTilePeriod:  prdata = 32'(tile_q);
      RegOctaveCount: prdata = 32'(octs_q);
      RegLacunarity:  prdata = 32'(lac_q);
      RegOctaveGain:  prdata = 32'(gain_q);
      default:        prdata = '0;
    endcase
  end

  assign chain_in[0] = '{freq: FreqOne,
                         period: (tile_q == '0) ? 32'd1 : 32'(tile_q),
                         amp: AmpOne};

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_cell
    tvn_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .par_i  (chain_in[k]),
      .lac_i  (lac_q),
      .gain_i (gain_q),
      .par_o  (cell_par[k]),
      .next_o (cell_nxt[k])
    );
    if (k + 1 < MAX_OCTAVES) begin : g_link
      assign chain_in[k+1] = cell_nxt[k];
    end
  end

  assign oct_n = (32'(octs_q) > MAX_OCTAVES) ? OctW'(MAX_OCTAVES) : OctW'(octs_q);

  tvn_engine #(
    .MAX_OCTAVES (MAX_OCTAVES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid && eng_ready),
    .x_i         (s_axis_tdata[31:0]),
    .y_i         (s_axis_tdata[63:32]),
    .oct_n_i     (oct_n),
    .par_i       (cell_par[oct_idx]),
    .oct_idx_o   (oct_idx),
    .ready_o     (eng_ready),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .noise_o     (res_noise),
    .sat_o       (res_sat)
  );

  assign s_axis_tready = eng_ready;
  assign res_take      = res_valid && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_take) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      m_noise_q <= res_noise;
      m_sat_q   <= res_sat;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_noise_q;
  assign m_axis_tuser  = m_sat_q;

endmodule

`default_nettype wire

>>> rtl/tvn_checker.sv
// Port-level checks of the tiling value noise fBm top level, bound to it.
// Uses tiling_value_noise_fbm_macros.svh.
`default_nettype none
`include "tiling_value_noise_fbm_macros.svh"

module tvn_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser,
  input wire logic        psel,
  input wire logic        pready
);

  // one request in flight, stalled result held, no early result, register port ready
  `TVN_ASSERT_NEXT(a_in_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")
  `TVN_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `TVN_ASSERT_NEXT(a_min_lat, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid, "result too early")
  `TVN_ASSERT(a_apb_ready, psel, pready, "register port not ready")

endmodule

bind tiling_value_noise_fbm tvn_checker u_tvn_checker (.*);

`default_nettype wire

>>> verif/tiling_value_noise_fbm_tb.sv
// Self-checking bench for tiling_value_noise_fbm: stream requests in, noise results out,
// APB register writes between phases. Results are checked against an fBm predictor.
// Depends on rtl/tvn_pkg.sv and rtl/tiling_value_noise_fbm.sv.
`timescale 1ns / 100ps

module tiling_value_noise_fbm_tb;
  import tvn_pkg::*;

  localparam int unsigned MaxOct    = 8;
  localparam int unsigned IdleLimit = 6000;
  localparam int unsigned TailWait  = 400;
  localparam int unsigned SettleGap = 20;
  localparam int unsigned RandPhases = 16;
  localparam int unsigned PhaseItems = 80;

  typedef struct {
    logic [15:0] noise;
    logic        sat;
  } fbm_result_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [1:0]  known;  // bit0: noise typed in, bit1: sat typed in
    logic [15:0] noise;
    logic        sat;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // x_coord[31:0], y_coord[63:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // noise_value
  logic [0:0]  m_axis_tuser;        // coord_saturated
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tiling_value_noise_fbm u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // shadow registers
  logic [15:0] cfg_period = TilePeriodReset;
  logic [3:0]  cfg_octaves = OctaveCountReset;
  logic [15:0] cfg_lacun = LacunarityReset;
  logic [15:0] cfg_gain = OctaveGainReset;

  fbm_result_t expected_q[$];
  stim_row_t   pin_q[$];
  int unsigned err_cnt = 0;
  logic        quiet = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  task automatic note_error(input string msg);
    if (err_cnt < 10) $display("%0t ERROR %s", $realtime, msg);
    err_cnt++;
  endtask

  // ---------------- predictor ----------------
  function automatic longint scale_axis(input logic signed [31:0] c, input logic [63:0] freq,
                                        inout logic sat);
    longint       lc;
    logic [63:0]  mag;
    logic [127:0] p;
    logic [127:0] q;
    lc = c;
    mag = (lc < 0) ? 64'(-lc) : 64'(lc);
    p = 128'(mag) * 128'(freq);
    if (p > 128'hFFFF_FFFF_FFFF_FFFF) begin
      sat = 1'b1;
      return (lc < 0) ? -64'sd2147483648 : 64'sd2147483647;
    end
    if (lc < 0) begin
      q = (p >> 12) + 128'(p[11:0] != 0);
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return -64'sd2147483648;
      end
      return -longint'(q[63:0]);
    end
    q = p >> 12;
    if (q > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    return longint'(q[63:0]);
  endfunction

  function automatic logic [31:0] lattice_wrap(input longint v, input logic [31:0] per);
    longint r;
    r = v % longint'({32'd0, per});
    if (r < 0) r += longint'({32'd0, per});
    return r[31:0];
  endfunction

  function automatic longint corner_value(input logic [31:0] cx, input logic [31:0] cy);
    logic [31:0] h;
    h = cx * HashMulX + cy * HashMulY;
    h = (h ^ (h >> 13)) * HashMulMix;
    h = h ^ (h >> 16);
    return longint'({40'd0, h[23:0]});
  endfunction

  function automatic longint smooth_frac(input longint s);
    longint t;
    t = s & 64'hFFFF;
    return ((t * t) * (196608 - 2 * t)) >>> 32;
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint f);
    return a + (((b - a) * f) >>> 16);
  endfunction

  function automatic longint octave_noise(input longint sx, input longint sy,
                                          input logic [31:0] per);
    longint xi, yi, u, v, a, b;
    logic [31:0] x0, x1, y0, y1;
    xi = sx >>> 16;
    yi = sy >>> 16;
    x0 = lattice_wrap(xi, per);
    x1 = lattice_wrap(xi + 1, per);
    y0 = lattice_wrap(yi, per);
    y1 = lattice_wrap(yi + 1, per);
    u = smooth_frac(sx);
    v = smooth_frac(sy);
    a = blend(corner_value(x0, y0), corner_value(x1, y0), u);
    b = blend(corner_value(x0, y1), corner_value(x1, y1), u);
    return blend(a, b, v);
  endfunction

  function automatic fbm_result_t fbm_predict(input logic [31:0] xc, input logic [31:0] yc);
    fbm_result_t  r;
    int unsigned  n;
    logic [63:0]  freq, per, amp, norm, acc;
    logic [127:0] wide;
    longint       sx, sy;
    logic         sat;
    n = (cfg_octaves > MaxOct) ? MaxOct : cfg_octaves;
    freq = 64'd4096;
    per = (cfg_period == 0) ? 64'd1 : 64'(cfg_period);
    amp = 64'd65536;
    norm = 0;
    acc = 0;
    sat = 1'b0;
    for (int unsigned k = 0; k < n; k++) begin
      sx = scale_axis(xc, freq, sat);
      sy = scale_axis(yc, freq, sat);
      acc += amp * 64'(octave_noise(sx, sy, per[31:0]));
      norm += amp;
      amp = (amp * 64'(cfg_gain)) >> 16;
      wide = (128'(freq) * 128'(cfg_lacun)) >> 12;
      freq = (wide > 128'(FreqCap)) ? 64'(FreqCap) : wide[63:0];
      wide = (128'(per) * 128'(cfg_lacun)) >> 12;
      per = (wide > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : wide[63:0];
      if (per < 1) per = 1;
    end
    r.noise = (norm != 0) ? 16'(acc / (norm << 8)) : 16'd0;
    r.sat = sat;
    return r;
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk_i) begin
    int unsigned nx;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      nx = 0;
      if ((m_axis_tvalid && m_axis_tready) || !m_axis_tready)
        nx = quiet ? 0 : $urandom_range(0, 7);
      if (!m_axis_tready) nx = 0;
      m_axis_tready <= (nx == 0);
      if (nx != 0) stall_left <= nx - 1;
    end
  end

  // ---------------- monitors, scoreboard, watchdog ----------------
  always @(posedge clk_i) begin
    fbm_result_t r;
    stim_row_t   pin;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pin = pin_q.pop_front();
        r = fbm_predict(s_axis_tdata[31:0], s_axis_tdata[63:32]);
        if (pin.known[0]) r.noise = pin.noise;
        if (pin.known[1]) r.sat = pin.sat;
        expected_q.push_back(r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          note_error($sformatf("result with no request pending: noise %h sat %b",
                               m_axis_tdata, m_axis_tuser));
        end else begin
          r = expected_q.pop_front();
          if (m_axis_tdata !== r.noise)
            note_error($sformatf("noise_value exp %h got %h", r.noise, m_axis_tdata));
          if (m_axis_tuser[0] !== r.sat)
            note_error($sformatf("coord_saturated exp %b got %b", r.sat, m_axis_tuser));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------- drivers ----------------
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] mask;
    mask = (idx == RegOctaveCount) ? 32'hF : 32'hFFFF;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegTilePeriod:  cfg_period = val[15:0];
      RegOctaveCount: cfg_octaves = val[3:0];
      RegLacunarity:  cfg_lacun = val[15:0];
      default:        cfg_gain = val[15:0];
    endcase
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== (val & mask))
      note_error($sformatf("reg %0d readback exp %h got %h", idx, val & mask, prdata));
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] per, input logic [3:0] oct,
                            input logic [15:0] lac, input logic [15:0] gain);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleGap) @(posedge clk_i);
    reg_write(RegTilePeriod, {16'd0, per});
    reg_write(RegOctaveCount, {28'd0, oct});
    reg_write(RegLacunarity, {16'd0, lac});
    reg_write(RegOctaveGain, {16'd0, gain});
    repeat (SettleGap) @(posedge clk_i);
  endtask

  task automatic send_request(input stim_row_t row);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pin_q.push_back(row);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {row.y, row.x};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      2: return ($urandom_range(0, 1) ? 32'h7FF0_0000 : 32'h8000_0000) + $urandom_range(0, 32'hF_FFFF);
      default: return {16'($urandom()), 16'd0};
    endcase
  endfunction

  stim_row_t rows_base[] = '{
    '{32'h0000_0000, 32'h0000_0000, 2'b11, 16'h0000, 1'b0},
    '{32'h7FFF_FFFF, 32'h0000_0000, 2'b10, 16'h0000, 1'b1},
    '{32'h8000_0000, 32'h0000_0000, 2'b10, 16'h0000, 1'b1},
    '{32'h0000_0000, 32'h7FFF_FFFF, 2'b10, 16'h0000, 1'b1},
    '{32'h0000_0000, 32'h8000_0000, 2'b10, 16'h0000, 1'b1},
    '{32'h8000_0000, 32'h7FFF_FFFF, 2'b10, 16'h0000, 1'b1},
    '{32'h0100_0000, 32'h0100_0000, 2'b11, 16'h0000, 1'b0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b00, 16'h0000, 1'b0},
    '{32'h0000_0001, 32'h0000_0001, 2'b00, 16'h0000, 1'b0},
    '{32'h0000_8000, 32'h0000_8000, 2'b00, 16'h0000, 1'b0},
    '{32'hFFFF_8000, 32'h0001_4000, 2'b00, 16'h0000, 1'b0},
    '{32'h00FF_0000, 32'h00FF_C000, 2'b00, 16'h0000, 1'b0},
    '{32'h0001_0000, 32'hFFFF_0000, 2'b00, 16'h0000, 1'b0},
    '{32'h3FFF_FFFF, 32'hC000_0000, 2'b00, 16'h0000, 1'b0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 2'b00, 16'h0000, 1'b0}
  };

  stim_row_t rows_zero_oct[] = '{
    '{32'h7FFF_FFFF, 32'h8000_0000, 2'b11, 16'h0000, 1'b0},
    '{32'h1234_5678, 32'h9ABC_DEF0, 2'b11, 16'h0000, 1'b0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 2'b11, 16'h0000, 1'b0}
  };

  logic [15:0] edge_cfg[5][4] = '{
    '{16'd1,     16'd8,  16'd65535, 16'd65535},
    '{16'd0,     16'd1,  16'd0,     16'd0},
    '{16'd65535, 16'd15, 16'd4096,  16'd65535},
    '{16'd65535, 16'd9,  16'd0,     16'd32768},
    '{16'd3,     16'd8,  16'd12288, 16'd40000}
  };

  initial begin
    stim_row_t row;
    logic [15:0] p, l, g;
    logic [3:0]  o;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows_base[i]) send_request(rows_base[i]);
    s_axis_tvalid <= 1'b0;
    set_config(TilePeriodReset, 4'd0, LacunarityReset, OctaveGainReset);
    foreach (rows_zero_oct[i]) send_request(rows_zero_oct[i]);
    s_axis_tvalid <= 1'b0;

    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      if (ph < 5) begin
        p = edge_cfg[ph][0]; o = edge_cfg[ph][1][3:0];
        l = edge_cfg[ph][2]; g = edge_cfg[ph][3];
      end else begin
        p = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(1, 300));
        o = $urandom_range(0, 3) == 0 ? 4'($urandom()) : 4'($urandom_range(1, 4));
        l = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(4096, 12288));
        g = 16'($urandom());
      end
      set_config(p, o, l, g);
      quiet = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < PhaseItems; i++) begin
        row.x = rand_coord();
        row.y = rand_coord();
        row.known = 2'b00;
        row.noise = '0;
        row.sat = 1'b0;
        send_request(row);
      end
      s_axis_tvalid <= 1'b0;
      quiet = 1'b0;
    end

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
    if (expected_q.size() != 0) note_error("requests left without result");
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/tvn_pkg.sv
rtl/tvn_cell.sv
rtl/tvn_engine.sv
rtl/tiling_value_noise_fbm.sv
rtl/tvn_checker.sv
verif/tiling_value_noise_fbm_tb.sv
